>>> rtl/core/p2r_pkg.sv
package p2r_pkg;

   // Angle codes in degrees, Q9.7.
   localparam logic signed [17:0] FULL_TURN    = 18'sd46080;
   localparam logic signed [17:0] HALF_TURN    = 18'sd23040;
   localparam logic signed [17:0] QUARTER_TURN = 18'sd11520;

   // Datapath widths.
   localparam int unsigned MAG_W   = 24;
   localparam int unsigned ANG_W   = 17;
   localparam int unsigned COORD_W = 25;
   localparam int unsigned RED_W   = 15;  // folded angle, -90..90 degrees
   localparam int unsigned VEC_W   = 56;  // vector components, 38 fraction bits
   localparam int unsigned PHS_W   = 44;  // residual angle, radians, 40 fraction bits
   localparam int unsigned GAIN_W  = 30;  // reciprocal gain, Q30
   localparam int unsigned GUARD_W = 30;

   localparam logic signed [25:0] OUT_LIMIT = 26'sd16777215;
   localparam logic [63:0]        Q60_ONE   = 64'h1000_0000_0000_0000;

   // Shift-and-subtract divide, used only while building constants.
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [63:0] rem;
      quo = '0;
      rem = '0;
      for (int k = 63; k >= 0; k--) begin
         rem = {rem[62:0], num[k]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[k] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Integer square root of a 64-bit value.
   function automatic logic [63:0] isqrt64(input logic [63:0] val);
      logic [63:0] rest;
      logic [63:0] res;
      logic [63:0] bit_v;
      rest  = val;
      res   = '0;
      bit_v = 64'h4000_0000_0000_0000;
      for (int k = 0; k < 32; k++) begin
         if (bit_v > rest) begin
            bit_v = bit_v >> 2;
         end
      end
      for (int k = 0; k < 32; k++) begin
         if (bit_v != '0) begin
            if (rest >= res + bit_v) begin
               rest = rest - (res + bit_v);
               res  = (res >> 1) + bit_v;
            end else begin
               res = res >> 1;
            end
            bit_v = bit_v >> 2;
         end
      end
      return res;
   endfunction

   // Arctangent of 1/m by its power series, 60 fraction bits.
   function automatic logic signed [63:0] atan_recip_q60(input logic [63:0] m);
      logic [63:0]        power;
      logic [63:0]        sq;
      logic signed [63:0] sum;
      logic signed [63:0] term;
      power = udiv64(Q60_ONE, m);
      sq    = m * m;
      sum   = '0;
      for (int k = 0; k < 64; k++) begin
         if (power != '0) begin
            term = $signed(udiv64(power, 64'(2 * k + 1)));
            if (k % 2 == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
            power = udiv64(power, sq);
         end
      end
      return sum;
   endfunction

   // Quarter of pi with 60 fraction bits (Machin formula).
   function automatic logic signed [63:0] quarter_pi_q60();
      return 4 * atan_recip_q60(64'd5) - atan_recip_q60(64'd239);
   endfunction

   // Rotation angle of micro-step idx, radians with 40 fraction bits.
   function automatic logic signed [PHS_W-1:0] step_angle(input int unsigned idx);
      logic signed [63:0] a;
      logic signed [63:0] q;
      if (idx == 0) begin
         a = quarter_pi_q60();
      end else begin
         a = atan_recip_q60(64'd1 << idx);
      end
      q = (a + 64'sd524288) >>> 20;
      return q[PHS_W-1:0];
   endfunction

   // Reciprocal of the CORDIC gain after a number of micro-steps, Q30.
   function automatic logic [GAIN_W-1:0] inv_gain(input int unsigned steps);
      logic [63:0] gain_sq;
      logic [63:0] q;
      gain_sq = Q60_ONE;
      for (int k = 0; k < steps; k++) begin
         gain_sq = gain_sq + (gain_sq >> (2 * k));
      end
      q = udiv64(Q60_ONE, isqrt64(gain_sq));
      return q[GAIN_W-1:0];
   endfunction

   // Degrees to radians, 50 fraction bits.
   function automatic logic [63:0] radians_per_degree();
      logic [63:0] pi_q60;
      pi_q60 = 64'(4 * quarter_pi_q60());
      return udiv64(pi_q60, 64'd180) >> 10;
   endfunction

endpackage

>>> rtl/core/polar_to_rect_convert_unit.sv
// Polar to rectangular converter: each beat of magnitude (unsigned Q16.8) and
// angle (signed Q9.7 degrees) yields one beat of x = r*cos and y = r*sin in
// signed Q16.8, rounded to nearest, by a fully unrolled CORDIC rotation with
// the gain removed up front. The pipeline takes one beat every clock cycle
// unless the result side stalls, and each beat passes through its stages in
// order: one stage folds the angle into -90..90 degrees, one forms the
// products for the radian conversion and the gain scaling, one adds them up,
// CORDIC_STEPS stages each do one micro-rotation, and the output register
// rounds and saturates. A stall on the result side holds the whole pipeline.
module polar_to_rect_convert_unit #(
   parameter int unsigned CORDIC_STEPS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [p2r_pkg::MAG_W-1:0]         req_magnitude,
   input  logic signed [p2r_pkg::ANG_W-1:0]  req_angle_degrees,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [p2r_pkg::COORD_W-1:0] rsp_x_coord,
   output logic signed [p2r_pkg::COORD_W-1:0] rsp_y_coord
);
   import p2r_pkg::*;

   localparam logic [GAIN_W-1:0] INV_GAIN = inv_gain(CORDIC_STEPS);
   localparam logic [63:0]       D2R      = radians_per_degree();

   logic advance;

   // Stage 1 registers.
   logic                     s1_vld_ff;
   logic [MAG_W-1:0]         s1_mag_ff;
   logic signed [RED_W-1:0]  s1_ang_ff, s1_ang_in;
   logic                     s1_neg_ff, s1_neg_in;

   // Stage 2 registers.
   logic                     s2_vld_ff;
   logic signed [39:0]       s2_plo_ff, s2_phi_ff;
   logic [MAG_W+GAIN_W-1:0]  s2_xr_ff;
   logic                     s2_neg_ff;

   // CORDIC stage registers, index 0 is the initial vector.
   logic                     vld_ff [0:CORDIC_STEPS];
   logic                     neg_ff [0:CORDIC_STEPS];
   logic signed [VEC_W-1:0]  x_ff   [0:CORDIC_STEPS];
   logic signed [VEC_W-1:0]  y_ff   [0:CORDIC_STEPS];
   logic signed [PHS_W-1:0]  z_ff   [0:CORDIC_STEPS];

   logic signed [63:0]       z_sum_in;
   logic signed [63:0]       z_rnd_in;

   // Output registers.
   logic                     rsp_valid_ff;
   logic signed [COORD_W-1:0] rsp_x_ff, rsp_x_in;
   logic signed [COORD_W-1:0] rsp_y_ff, rsp_y_in;

   // The pipeline moves unless a finished beat is held by the receiver.
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // Reduce the angle to one turn, then fold half turns into -90..90 degrees.
   always_comb begin
      logic signed [17:0] t0, t1, t2, t3, t4;
      t0 = 18'(req_angle_degrees);
      t1 = (t0 < 0) ? t0 + FULL_TURN : t0;
      t2 = (t1 < 0) ? t1 + FULL_TURN : t1;
      t3 = (t2 >= FULL_TURN) ? t2 - FULL_TURN : t2;
      t4 = (t3 >= HALF_TURN) ? t3 - FULL_TURN : t3;
      s1_neg_in = 1'b0;
      if (t4 > QUARTER_TURN) begin
         t4        = t4 - HALF_TURN;
         s1_neg_in = 1'b1;
      end else if (t4 < -QUARTER_TURN) begin
         t4        = t4 + HALF_TURN;
         s1_neg_in = 1'b1;
      end
      s1_ang_in = t4[RED_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff <= req_valid;
      end
      if (advance) begin
         s1_mag_ff <= req_magnitude;
         s1_ang_ff <= s1_ang_in;
         s1_neg_ff <= s1_neg_in;
      end
   end

   // Split the radian factor into two halves and scale r by the inverse gain.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (advance) begin
         s2_vld_ff <= s1_vld_ff;
      end
      if (advance) begin
         s2_plo_ff <= 40'(s1_ang_ff * $signed({1'b0, D2R[23:0]}));
         s2_phi_ff <= 40'(s1_ang_ff * $signed({1'b0, D2R[47:24]}));
         s2_xr_ff  <= s1_mag_ff * INV_GAIN;
         s2_neg_ff <= s1_neg_ff;
      end
   end

   // Combine the partial products into the starting angle in radians.
   assign z_sum_in = (64'(s2_phi_ff) <<< 24) + 64'(s2_plo_ff);
   assign z_rnd_in = (z_sum_in + 64'sd65536) >>> 17;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= s2_vld_ff;
      end
      if (advance) begin
         neg_ff[0] <= s2_neg_ff;
         x_ff[0]   <= $signed(VEC_W'(s2_xr_ff));
         y_ff[0]   <= '0;
         z_ff[0]   <= z_rnd_in[PHS_W-1:0];
      end
   end

   // One micro-rotation per stage, direction from the sign of the residual angle.
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      localparam logic signed [PHS_W-1:0] ANGLE = step_angle(i);
      logic signed [VEC_W-1:0] x_in, y_in;
      logic signed [PHS_W-1:0] z_in;

      always_comb begin
         if (z_ff[i] >= 0) begin
            x_in = x_ff[i] - (y_ff[i] >>> i);
            y_in = y_ff[i] + (x_ff[i] >>> i);
            z_in = z_ff[i] - ANGLE;
         end else begin
            x_in = x_ff[i] + (y_ff[i] >>> i);
            y_in = y_ff[i] - (x_ff[i] >>> i);
            z_in = z_ff[i] + ANGLE;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (advance) begin
            vld_ff[i+1] <= vld_ff[i];
         end
         if (advance) begin
            neg_ff[i+1] <= neg_ff[i];
            x_ff[i+1]   <= x_in;
            y_ff[i+1]   <= y_in;
            z_ff[i+1]   <= z_in;
         end
      end
   end

   // Drop the guard bits with rounding, undo the half-turn fold, saturate.
   always_comb begin
      logic signed [VEC_W-1:0] xr, yr;
      logic signed [25:0]      xq, yq;
      xr = (x_ff[CORDIC_STEPS] + VEC_W'(64'sd1 <<< (GUARD_W - 1))) >>> GUARD_W;
      yr = (y_ff[CORDIC_STEPS] + VEC_W'(64'sd1 <<< (GUARD_W - 1))) >>> GUARD_W;
      xq = xr[25:0];
      yq = yr[25:0];
      if (neg_ff[CORDIC_STEPS]) begin
         xq = -xq;
         yq = -yq;
      end
      if (xq > OUT_LIMIT) begin
         xq = OUT_LIMIT;
      end else if (xq < -OUT_LIMIT) begin
         xq = -OUT_LIMIT;
      end
      if (yq > OUT_LIMIT) begin
         yq = OUT_LIMIT;
      end else if (yq < -OUT_LIMIT) begin
         yq = -OUT_LIMIT;
      end
      rsp_x_in = xq[COORD_W-1:0];
      rsp_y_in = yq[COORD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= vld_ff[CORDIC_STEPS];
      end
      if (advance) begin
         rsp_x_ff <= rsp_x_in;
         rsp_y_ff <= rsp_y_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_x_coord = rsp_x_ff;
   assign rsp_y_coord = rsp_y_ff;

endmodule
